>>> rtl/core/iebfd_pkg.sv
package iebfd_pkg;

    localparam int TICK_BITS      = 24;
    localparam int ADDRESS_BITS   = 12;
    localparam int VALUE_BITS     = 12;
    localparam int BYTE_BITS      = 8;
    localparam int CTRL_BITS      = 4;
    localparam int COUNT_BITS     = 4;
    localparam int KIND_BITS      = 3;
    localparam int REG_INDEX_BITS = 3;

    typedef logic [TICK_BITS-1:0]  tick_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;
    typedef logic [KIND_BITS-1:0]  kind_t;

    typedef struct packed {
        tick_t start_width;
        tick_t start_tolerance;
        tick_t one_width;
        tick_t zero_width;
        tick_t bit_tolerance;
    } cfg_t;

    typedef struct packed {
        logic is_start;
        logic is_one;
        logic is_zero;
    } cls_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BCAST,
        PH_MASTER,
        PH_SLAVE,
        PH_CTRL,
        PH_LEN,
        PH_DATA
    } phase_t;

    localparam kind_t KIND_START  = 3'd0;
    localparam kind_t KIND_BCAST  = 3'd1;
    localparam kind_t KIND_MASTER = 3'd2;
    localparam kind_t KIND_SLAVE  = 3'd3;
    localparam kind_t KIND_CTRL   = 3'd4;
    localparam kind_t KIND_LEN    = 3'd5;
    localparam kind_t KIND_DATA   = 3'd6;

    localparam logic [REG_INDEX_BITS-1:0] REG_START_WIDTH     = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_START_TOLERANCE = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_ONE_WIDTH       = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_ZERO_WIDTH      = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_BIT_TOLERANCE   = 3'd4;

endpackage

>>> rtl/core/iebfd_classify.sv
module iebfd_classify
(
    input  iebfd_pkg::tick_t width,
    input  iebfd_pkg::cfg_t  cfg,
    output iebfd_pkg::cls_t  cls
);

    // strict window: nom - tol < w < nom + tol, one bit of headroom
    function automatic logic in_window
    (
        input iebfd_pkg::tick_t w,
        input iebfd_pkg::tick_t nom,
        input iebfd_pkg::tick_t tol
    );
        logic [iebfd_pkg::TICK_BITS:0] lo_sum;
        logic [iebfd_pkg::TICK_BITS:0] hi_sum;
        begin
            lo_sum    = {1'b0, w} + {1'b0, tol};
            hi_sum    = {1'b0, nom} + {1'b0, tol};
            in_window = (lo_sum > {1'b0, nom}) && ({1'b0, w} < hi_sum);
        end
    endfunction

    logic one_hit;
    logic zero_hit;

    assign one_hit      = in_window(width, cfg.one_width, cfg.bit_tolerance);
    assign zero_hit     = in_window(width, cfg.zero_width, cfg.bit_tolerance);
    assign cls.is_one   = one_hit;
    assign cls.is_zero  = !one_hit && zero_hit;
    assign cls.is_start = in_window(width, cfg.start_width, cfg.start_tolerance);

endmodule

>>> rtl/core/iebfd_fsm.sv
module iebfd_fsm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_level,
    input  iebfd_pkg::cls_t     cls,
    output logic                item_take,
    output logic                out_valid,
    input  logic                out_stall,
    output iebfd_pkg::kind_t    kind,
    output iebfd_pkg::value_t   value,
    output logic                nak
);

    iebfd_pkg::phase_t phase_reg;
    iebfd_pkg::phase_t phase_next;
    iebfd_pkg::count_t bit_count_reg;
    iebfd_pkg::count_t bit_count_next;
    iebfd_pkg::value_t shift_reg;
    iebfd_pkg::value_t shift_next;
    iebfd_pkg::byte_t  bytes_left_reg;
    iebfd_pkg::byte_t  bytes_left_next;
    iebfd_pkg::byte_t  bytes_dec;

    logic              out_valid_reg;
    iebfd_pkg::kind_t  kind_reg;
    iebfd_pkg::value_t value_reg;
    logic              nak_reg;

    logic              fire;
    logic              emit;
    iebfd_pkg::kind_t  emit_kind;
    iebfd_pkg::value_t emit_value;
    logic              emit_nak;
    iebfd_pkg::count_t field_bits;
    logic              bit_valid;

    assign item_take  = item_valid && (!out_valid_reg || !out_stall);
    assign fire       = item_take && item_level;
    assign bit_valid  = cls.is_one || cls.is_zero;
    assign bytes_dec  = bytes_left_reg - 8'd1;
    assign field_bits = (phase_reg == iebfd_pkg::PH_CTRL)
                        ? iebfd_pkg::count_t'(iebfd_pkg::CTRL_BITS)
                        : iebfd_pkg::count_t'(iebfd_pkg::BYTE_BITS);

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        unique case (phase_reg)
            iebfd_pkg::PH_HUNT:
            begin
                if (cls.is_start)
                begin
                    phase_next     = iebfd_pkg::PH_BCAST;
                    bit_count_next = '0;
                    shift_next     = '0;
                end
            end
            iebfd_pkg::PH_BCAST:
            begin
                phase_next     = iebfd_pkg::PH_MASTER;
                bit_count_next = '0;
                shift_next     = '0;
            end
            iebfd_pkg::PH_MASTER, iebfd_pkg::PH_SLAVE:
            begin
                if (!bit_valid)
                begin
                    phase_next      = iebfd_pkg::PH_HUNT;
                    bit_count_next  = '0;
                    shift_next      = '0;
                    bytes_left_next = '0;
                end
                else if (bit_count_reg < iebfd_pkg::count_t'(iebfd_pkg::ADDRESS_BITS))
                begin
                    shift_next     = {shift_reg[iebfd_pkg::VALUE_BITS-2:0], cls.is_one};
                    bit_count_next = bit_count_reg + 4'd1;
                end
                else if (bit_count_reg == iebfd_pkg::count_t'(iebfd_pkg::ADDRESS_BITS))
                begin
                    // parity dropped
                    if (phase_reg == iebfd_pkg::PH_MASTER)
                    begin
                        phase_next     = iebfd_pkg::PH_SLAVE;
                        bit_count_next = '0;
                        shift_next     = '0;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 4'd1;
                    end
                end
                else
                begin
                    bit_count_next = '0;
                    shift_next     = '0;
                    if (cls.is_one)
                    begin
                        phase_next      = iebfd_pkg::PH_HUNT;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        phase_next = iebfd_pkg::PH_CTRL;
                    end
                end
            end
            iebfd_pkg::PH_CTRL, iebfd_pkg::PH_LEN, iebfd_pkg::PH_DATA:
            begin
                if (bit_count_reg < field_bits)
                begin
                    shift_next     = {4'd0, shift_reg[iebfd_pkg::BYTE_BITS-2:0], cls.is_one};
                    bit_count_next = bit_count_reg + 4'd1;
                end
                else if (bit_count_reg == field_bits)
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
                else
                begin
                    bit_count_next = '0;
                    shift_next     = '0;
                    if (phase_reg == iebfd_pkg::PH_CTRL)
                    begin
                        phase_next = iebfd_pkg::PH_LEN;
                    end
                    else if (phase_reg == iebfd_pkg::PH_LEN)
                    begin
                        bytes_left_next = shift_reg[iebfd_pkg::BYTE_BITS-1:0];
                        phase_next      = (shift_reg[iebfd_pkg::BYTE_BITS-1:0] == 8'd0)
                                          ? iebfd_pkg::PH_HUNT : iebfd_pkg::PH_DATA;
                    end
                    else
                    begin
                        bytes_left_next = bytes_dec;
                        phase_next      = (bytes_dec == 8'd0)
                                          ? iebfd_pkg::PH_HUNT : iebfd_pkg::PH_DATA;
                    end
                end
            end
            default:
            begin
                phase_next      = iebfd_pkg::PH_HUNT;
                bit_count_next  = '0;
                shift_next      = '0;
                bytes_left_next = '0;
            end
        endcase
    end

    always_comb
    begin
        emit       = 1'b0;
        emit_kind  = iebfd_pkg::KIND_START;
        emit_value = '0;
        emit_nak   = 1'b0;
        unique case (phase_reg)
            iebfd_pkg::PH_HUNT:
            begin
                emit = cls.is_start;
            end
            iebfd_pkg::PH_BCAST:
            begin
                emit       = 1'b1;
                emit_kind  = iebfd_pkg::KIND_BCAST;
                emit_value = {{(iebfd_pkg::VALUE_BITS-1){1'b0}}, cls.is_one};
            end
            iebfd_pkg::PH_MASTER:
            begin
                emit       = bit_valid
                             && (bit_count_reg == iebfd_pkg::count_t'(iebfd_pkg::ADDRESS_BITS));
                emit_kind  = iebfd_pkg::KIND_MASTER;
                emit_value = shift_reg;
            end
            iebfd_pkg::PH_SLAVE:
            begin
                emit       = bit_valid
                             && (bit_count_reg > iebfd_pkg::count_t'(iebfd_pkg::ADDRESS_BITS));
                emit_kind  = iebfd_pkg::KIND_SLAVE;
                emit_value = shift_reg;
            end
            iebfd_pkg::PH_CTRL, iebfd_pkg::PH_LEN, iebfd_pkg::PH_DATA:
            begin
                emit       = bit_count_reg > field_bits;
                emit_kind  = (phase_reg == iebfd_pkg::PH_CTRL) ? iebfd_pkg::KIND_CTRL
                           : (phase_reg == iebfd_pkg::PH_LEN)  ? iebfd_pkg::KIND_LEN
                           : iebfd_pkg::KIND_DATA;
                emit_value = shift_reg;
                emit_nak   = cls.is_one;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= iebfd_pkg::PH_HUNT;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                bytes_left_reg <= bytes_left_next;
            end
            if (item_take)
            begin
                out_valid_reg <= fire && emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            nak_reg   <= emit_nak;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign nak       = nak_reg;

`ifndef NO_ASSERTIONS
    a_hunt_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == iebfd_pkg::PH_HUNT |-> bytes_left_reg == 8'd0)
        else $error("bytes left while hunting");

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == iebfd_pkg::PH_DATA |-> bytes_left_reg != 8'd0)
        else $error("data phase with no bytes left");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd13)
        else $error("bit count out of range");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == iebfd_pkg::KIND_START |-> value_reg == '0 && !nak_reg)
        else $error("start transaction carries data");

    a_hunt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == iebfd_pkg::PH_HUNT && !cls.is_start
        |=> phase_reg == iebfd_pkg::PH_HUNT && !out_valid_reg)
        else $error("left hunting without a start pulse");
`endif

endmodule

>>> rtl/core/iebus_frame_decoder.sv
// An accepted transaction passes through the input register and the classifier to the registered result.
// Throughput: one input transaction per cycle while results are taken; a stalled result
// blocks the decoder, so one further transaction waits in the input register and then
// in_stall rises until the result is taken.
// Reset: rst_n asynchronous, active low; clears configuration to zero, the decoder
// to hunting for a start pulse, and both valid flags.
module iebus_frame_decoder
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [iebfd_pkg::REG_INDEX_BITS-1:0]    cfg_index,
    input  iebfd_pkg::tick_t                        cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    level,
    input  iebfd_pkg::tick_t                        width,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output iebfd_pkg::kind_t                        kind,
    output iebfd_pkg::value_t                       value,
    output logic                                    nak
);

    iebfd_pkg::cfg_t  cfg_reg;
    logic             s1_valid_reg;
    logic             s1_level_reg;
    iebfd_pkg::tick_t s1_width_reg;
    logic             accept;
    logic             item_take;
    iebfd_pkg::cls_t  cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                iebfd_pkg::REG_START_WIDTH:     cfg_reg.start_width     <= cfg_data;
                iebfd_pkg::REG_START_TOLERANCE: cfg_reg.start_tolerance <= cfg_data;
                iebfd_pkg::REG_ONE_WIDTH:       cfg_reg.one_width       <= cfg_data;
                iebfd_pkg::REG_ZERO_WIDTH:      cfg_reg.zero_width      <= cfg_data;
                iebfd_pkg::REG_BIT_TOLERANCE:   cfg_reg.bit_tolerance   <= cfg_data;
                default:                        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign in_stall = s1_valid_reg && !item_take;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_level_reg <= level;
            s1_width_reg <= width;
        end
    end

    iebfd_classify u_classify
    (
        .width (s1_width_reg),
        .cfg   (cfg_reg),
        .cls   (cls)
    );

    iebfd_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item_level (s1_level_reg),
        .cls        (cls),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value      (value),
        .nak        (nak)
    );

endmodule
